// ----- rtl/ckt_pkg.sv -----
// ============================================================================
// ckt_pkg: shared types and constants of the compacting keyed table
// Holds the slot count, the transfer payload structs, the operation and
// status codes, and the per-slot command and update structs.
// ============================================================================
package ckt_pkg;

    // Table geometry.
    localparam int CAPACITY = 16;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Fixed widths of the result fields.
    localparam int OUT_SLOT_W  = 4;
    localparam int OUT_TOTAL_W = 5;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Input item.
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] kind_word0;
        logic [63:0] kind_word1;
        logic [63:0] kind_word2;
        logic [31:0] amount_in;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [4:0]  entry_total;
        logic [63:0] found_kind0;
        logic [63:0] found_kind1;
        logic [63:0] found_kind2;
        logic [31:0] found_amount;
    } t_out;

    // Name key of one entry.
    typedef struct packed {
        logic [63:0] word0;
        logic [63:0] word1;
        logic [63:0] word2;
    } t_key;

    // Contents of one slot.
    typedef struct packed {
        t_key        name;
        logic [63:0] kind0;
        logic [63:0] kind1;
        logic [63:0] kind2;
        logic [31:0] amount;
    } t_entry;

    // Command to one slot cell.
    typedef struct packed {
        logic load;   // take the new entry
        logic shift;  // take the upper neighbor's entry
        logic drop;   // clear the valid bit
    } t_cell_cmd;

    // Table update requested by the controller.
    typedef struct packed {
        logic               insert;
        logic               remove;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } t_act;

endpackage

// ----- rtl/ckt_cell.sv -----
// ============================================================================
// ckt_cell: one slot of the table
// Stores one entry and its valid bit, compares its name against the key and
// loads a new entry, its upper neighbor's entry, or drops its valid bit.
// ============================================================================
module ckt_cell
    import ckt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_entry    i_new,
    input  t_entry    i_next,
    input  logic      i_next_valid,
    input  t_key      i_key,
    output logic      o_valid,
    output t_entry    o_entry,
    output logic      o_match
);

    logic   r_valid;
    t_entry r_entry;

    // Valid bit follows the command; reset empties the slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_valid <= 1'b1;
        end else if (i_cmd.shift) begin
            r_valid <= i_next_valid;
        end else if (i_cmd.drop) begin
            r_valid <= 1'b0;
        end
    end

    // Entry payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_entry <= i_new;
        end else if (i_cmd.shift) begin
            r_entry <= i_next;
        end
    end

    // Full 24-byte name compare.
    assign o_match = r_valid && (r_entry.name == i_key);
    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

// ----- rtl/ckt_chain.sv -----
// ============================================================================
// ckt_chain: row of slot cells
// Decodes a table update into per-slot commands, links each cell to its
// upper neighbor for the compacting shift and reads out one selected slot.
// ============================================================================
module ckt_chain
    import ckt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_act                i_act,
    input  t_entry              i_new,
    input  t_key                i_key,
    input  logic [SLOT_W-1:0]   i_rd_idx,
    output logic [CAPACITY-1:0] o_valid,
    output logic [CAPACITY-1:0] o_match,
    output t_entry              o_rd_entry
);

    t_entry w_entry [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [COUNT_W-1:0] IDX      = COUNT_W'(g);
        localparam logic [COUNT_W-1:0] IDX_NEXT = COUNT_W'(g + 1);

        t_cell_cmd w_cmd;
        t_entry    w_next;
        logic      w_next_valid;

        // Insert lands at the fill count; remove shifts the slots above the
        // hit down by one and drops the top occupied slot.
        always_comb begin
            w_cmd.load  = i_act.insert && (i_act.count == IDX);
            w_cmd.shift = i_act.remove && (IDX >= COUNT_W'(i_act.slot))
                          && (IDX_NEXT < i_act.count);
            w_cmd.drop  = i_act.remove && (IDX_NEXT == i_act.count);
        end

        // The top cell has no upper neighbor.
        if (g == CAPACITY - 1) begin : g_top
            assign w_next       = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_link
            assign w_next       = w_entry[g + 1];
            assign w_next_valid = o_valid[g + 1];
        end

        ckt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new        (i_new),
            .i_next       (w_next),
            .i_next_valid (w_next_valid),
            .i_key        (i_key),
            .o_valid      (o_valid[g]),
            .o_entry      (w_entry[g]),
            .o_match      (o_match[g])
        );
    end

    // Readout of the found slot.
    assign o_rd_entry = w_entry[i_rd_idx];

endmodule

// ----- rtl/compacting_keyed_table.sv -----
// ============================================================================
// compacting_keyed_table: packed table of named entries
// Flow: the request is registered, the cells compare it in S_MATCH, the match
// vector is registered, and S_APPLY updates the chain and registers the result.
// A new item is taken only when idle or as the previous result is registered.
// Reset: synchronous, active low; clears all valid bits and the fill count.
// ============================================================================
module compacting_keyed_table
    import ckt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state               r_state, n_state;
    t_in                  r_req;
    logic [CAPACITY-1:0]  r_hit;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_out_valid;
    t_out                 r_out, n_out;

    logic                 w_in_fire, w_out_free, w_out_fire;
    logic [CAPACITY-1:0]  w_valid, w_match;
    logic [SLOT_W-1:0]    w_hit_idx;
    logic                 w_hit_any;
    t_entry               w_rd_entry, w_new;
    t_key                 w_key;
    t_act                 w_act;

    // Handshake: a new item enters while the previous result waits.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_fire = (r_state == S_APPLY) && w_out_free;
    assign o_in_ready = (r_state == S_IDLE) || w_out_fire;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // Request payload.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_req <= i_in_data;
        end
    end

    assign w_key.word0 = r_req.key_word0;
    assign w_key.word1 = r_req.key_word1;
    assign w_key.word2 = r_req.key_word2;

    always_comb begin
        w_new.name   = w_key;
        w_new.kind0  = r_req.kind_word0;
        w_new.kind1  = r_req.kind_word1;
        w_new.kind2  = r_req.kind_word2;
        w_new.amount = r_req.amount_in;
    end

    // Match vector is captured after the compare cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MATCH) begin
            r_hit <= w_match;
        end
    end

    // Lowest matching slot.
    always_comb begin
        w_hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                w_hit_idx = SLOT_W'(i);
            end
        end
    end
    assign w_hit_any = |r_hit;

    // Operation decode and result.
    always_comb begin
        n_count            = r_count;
        n_out              = '0;
        w_act              = '0;
        w_act.count        = r_count;
        n_out.status       = ST_OK;
        case (t_op'(r_req.op))
            OP_INSERT: begin
                if (r_count == COUNT_W'(CAPACITY)) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_out.slot   = OUT_SLOT_W'(r_count);
                    w_act.insert = w_out_fire;
                    n_count      = r_count + 1'b1;
                end
            end
            OP_REMOVE, OP_SEARCH: begin
                if (r_count == '0) begin
                    n_out.status = ST_EMPTY;
                end else if (!w_hit_any) begin
                    n_out.status = ST_MISSING;
                end else begin
                    n_out.slot = OUT_SLOT_W'(w_hit_idx);
                    if (t_op'(r_req.op) == OP_SEARCH) begin
                        n_out.found_kind0  = w_rd_entry.kind0;
                        n_out.found_kind1  = w_rd_entry.kind1;
                        n_out.found_kind2  = w_rd_entry.kind2;
                        n_out.found_amount = w_rd_entry.amount;
                    end else begin
                        w_act.remove = w_out_fire;
                        w_act.slot   = w_hit_idx;
                        n_count      = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        n_out.entry_total = OUT_TOTAL_W'(n_count);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_out_fire) begin
                    n_state = w_in_fire ? S_MATCH : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_out_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ckt_chain u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_act      (w_act),
        .i_new      (w_new),
        .i_key      (w_key),
        .i_rd_idx   (w_hit_idx),
        .o_valid    (w_valid),
        .o_match    (w_match),
        .o_rd_entry (w_rd_entry)
    );

`ifndef SYNTHESIS
    // Occupied slots always number exactly the fill count.
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == r_count)
        else $error("valid bits disagree with fill count");

    // The table stays packed in the low slots.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("valid slots are not packed");

    // A captured match never points at an empty slot.
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> ((r_hit & ~w_valid) == '0))
        else $error("match on an empty slot");

    // A successful remove shrinks the table by one.
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_act.remove |=> (r_count == $past(r_count) - 1'b1))
        else $error("remove did not decrement the fill count");
`endif

endmodule
